// ----- rtl/rotation_matrix_to_quaternion_core_defines.svh -----
// assertion macros shared by the rotation matrix to quaternion rtl
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RMQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RMQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rmq_pkg.sv -----
// shared types and constants for the rotation matrix to quaternion core
package rmq_pkg;

    localparam int ROT_FRAC_BITS_DEF = 16;
    localparam int POS_WIDTH_DEF     = 32;

    // branch of the shepperd selection
    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } branch_t;

endpackage

// ----- rtl/rmq_pose_if.sv -----
// input channel: rotation entries and translation of one transform
interface rmq_pose_if #(
    parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF,
    parameter int POS_WIDTH     = rmq_pkg::POS_WIDTH_DEF
);
    localparam int RW = ROT_FRAC_BITS + 2;

    logic                 valid;
    logic                 ready;
    logic signed [RW-1:0] r00, r01, r02;
    logic signed [RW-1:0] r10, r11, r12;
    logic signed [RW-1:0] r20, r21, r22;
    logic signed [POS_WIDTH-1:0] pos_x_in, pos_y_in, pos_z_in;

    modport source (
        output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
        output pos_x_in, pos_y_in, pos_z_in,
        input  ready
    );
    modport sink (
        input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
        input  pos_x_in, pos_y_in, pos_z_in,
        output ready
    );
endinterface

// ----- rtl/rmq_result_if.sv -----
// output channel: translation and quaternion of one transform
interface rmq_result_if #(
    parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF,
    parameter int POS_WIDTH     = rmq_pkg::POS_WIDTH_DEF
);
    localparam int RW = ROT_FRAC_BITS + 2;

    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] pos_x_out, pos_y_out, pos_z_out;
    logic signed [RW-1:0]        quat_w, quat_x, quat_y, quat_z;

    modport source (
        output valid, pos_x_out, pos_y_out, pos_z_out,
        output quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x_out, pos_y_out, pos_z_out,
        input  quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

// ----- rtl/rmq_prep.sv -----
// first stage: branch choice, root argument and the three numerators
module rmq_prep #(
    parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 adv,
    input  logic signed [ROT_FRAC_BITS+1:0]      m [9],
    output logic [2*ROT_FRAC_BITS+3:0]           sq_arg,
    output logic [2:0][ROT_FRAC_BITS+2:0]        num,
    output rmq_pkg::branch_t                     br
);
    import rmq_pkg::*;

    localparam int F   = ROT_FRAC_BITS;
    localparam int RW  = F + 2;
    localparam int TW  = RW + 2;
    localparam int AW  = RW + 3;
    localparam int NMW = RW + 1;
    localparam int SW  = 2 * F + 4;

    logic signed [TW-1:0]  tr;
    logic signed [AW-1:0]  one_c;
    logic signed [AW-1:0]  arg;
    logic [AW-2:0]         arg_u;
    branch_t               br_c;
    logic signed [NMW-1:0] d21_12, d02_20, d10_01, s01, s02, s12;
    logic [2:0][NMW-1:0]   num_c;

    logic [SW-1:0]         sq_arg_reg;
    logic [2:0][NMW-1:0]   num_reg;
    branch_t               br_reg;

    assign tr    = TW'(m[0]) + TW'(m[4]) + TW'(m[8]);
    assign one_c = AW'(1) << F;

    always_comb
    begin
        if (tr > 0)
            br_c = BR_TRACE;
        else if (m[0] > m[4] && m[0] > m[8])
            br_c = BR_X;
        else if (m[4] > m[8])
            br_c = BR_Y;
        else
            br_c = BR_Z;
    end

    assign d21_12 = NMW'(m[7]) - NMW'(m[5]);
    assign d02_20 = NMW'(m[2]) - NMW'(m[6]);
    assign d10_01 = NMW'(m[3]) - NMW'(m[1]);
    assign s01    = NMW'(m[1]) + NMW'(m[3]);
    assign s02    = NMW'(m[2]) + NMW'(m[6]);
    assign s12    = NMW'(m[5]) + NMW'(m[7]);

    always_comb
    begin
        unique case (br_c)
            BR_TRACE:
            begin
                arg   = AW'(tr) + one_c;
                num_c = {d10_01, d02_20, d21_12};
            end
            BR_X:
            begin
                arg   = one_c + AW'(m[0]) - AW'(m[4]) - AW'(m[8]);
                num_c = {s02, s01, d21_12};
            end
            BR_Y:
            begin
                arg   = one_c + AW'(m[4]) - AW'(m[0]) - AW'(m[8]);
                num_c = {s12, s01, d02_20};
            end
            default:
            begin
                arg   = one_c + AW'(m[8]) - AW'(m[0]) - AW'(m[4]);
                num_c = {s12, s02, d10_01};
            end
        endcase
    end

    // negative argument clamps to zero
    assign arg_u = (arg > 0) ? arg[AW-2:0] : '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_arg_reg <= {arg_u, {F{1'b0}}};
            num_reg    <= num_c;
            br_reg     <= br_c;
        end
    end

    assign sq_arg = sq_arg_reg;
    assign num    = num_reg;
    assign br     = br_reg;
endmodule

// ----- rtl/rmq_sqrt.sv -----
// pipelined integer square root, one result bit per stage
module rmq_sqrt #(
    parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         adv,
    input  logic [2*ROT_FRAC_BITS+3:0]   arg,
    output logic [ROT_FRAC_BITS+1:0]     root
);
    import rmq_pkg::*;

    localparam int F    = ROT_FRAC_BITS;
    localparam int SW   = 2 * F + 4;
    localparam int NS   = F + 2;
    localparam int RTW  = F + 2;
    localparam int REMW = F + 3;
    localparam int CW   = F + 5;

    logic [SW-1:0]   rad_reg  [NS];
    logic [REMW-1:0] rem_reg  [NS];
    logic [RTW-1:0]  root_reg [NS];

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic [SW-1:0]   rad_p;
        logic [REMW-1:0] rem_p;
        logic [RTW-1:0]  root_p;
        logic [CW-1:0]   rem_sh;
        logic [CW-1:0]   trial;
        logic            ge;

        if (i == 0)
        begin : g_first
            assign rad_p  = arg;
            assign rem_p  = '0;
            assign root_p = '0;
        end
        else
        begin : g_next
            assign rad_p  = rad_reg[i-1];
            assign rem_p  = rem_reg[i-1];
            assign root_p = root_reg[i-1];
        end

        assign rem_sh = {rem_p, rad_p[SW-1:SW-2]};
        assign trial  = CW'({root_p, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[i]  <= rad_p << 2;
                rem_reg[i]  <= ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
                root_reg[i] <= {root_p[RTW-2:0], ge};
            end
        end
    end

    assign root = root_reg[NS-1];
endmodule

// ----- rtl/rmq_div.sv -----
// pipelined rounded division num / (2 root), saturated, one quotient bit per stage
module rmq_div #(
    parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            adv,
    input  logic signed [ROT_FRAC_BITS+2:0] num,
    input  logic [ROT_FRAC_BITS+1:0]        root,
    output logic signed [ROT_FRAC_BITS+1:0] q
);
    import rmq_pkg::*;

    localparam int F   = ROT_FRAC_BITS;
    localparam int RW  = F + 2;
    localparam int NMW = F + 3;
    localparam int NW  = 2 * F + 3;
    localparam int DW  = F + 3;
    localparam int CW  = 2 * F + 4;
    localparam int QW  = F + 1;
    localparam int NB  = F + 1;

    logic [NMW-1:0] mag;
    logic [NW-1:0]  n0;
    logic [DW-1:0]  d0;

    logic [NW-1:0]  rem_reg  [NB+1];
    logic [DW-1:0]  d_reg    [NB+1];
    logic [QW-1:0]  q_reg    [NB+1];
    logic           sat_reg  [NB+1];
    logic           neg_reg  [NB+1];
    logic           zero_reg [NB+1];

    logic signed [RW-1:0] res;
    logic signed [RW-1:0] out_reg;

    // magnitude of the most negative sum still reads correctly unsigned
    assign mag = num[NMW-1] ? NMW'(-num) : NMW'(num);
    assign n0  = NW'({mag, {F{1'b0}}}) + NW'(root);
    assign d0  = {root, 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= n0;
            d_reg[0]    <= d0;
            q_reg[0]    <= '0;
            sat_reg[0]  <= CW'(n0) >= (CW'(d0) << (F + 1));
            neg_reg[0]  <= num[NMW-1];
            zero_reg[0] <= (num == '0);
        end
    end

    for (genvar j = 1; j <= NB; j++)
    begin : g_bit
        localparam int K = NB - j;
        logic [CW-1:0] trial;
        logic          ge;

        assign trial = CW'(d_reg[j-1]) << K;
        assign ge    = CW'(rem_reg[j-1]) >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= ge ? NW'(CW'(rem_reg[j-1]) - trial) : rem_reg[j-1];
                q_reg[j]    <= ge ? (q_reg[j-1] | (QW'(1) << K)) : q_reg[j-1];
                d_reg[j]    <= d_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[NB])
            res = '0;
        else if (sat_reg[NB])
            res = neg_reg[NB] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
        else if (neg_reg[NB])
            res = -$signed({1'b0, q_reg[NB]});
        else
            res = $signed({1'b0, q_reg[NB]});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end

    assign q = out_reg;
endmodule

// ----- rtl/rotation_matrix_to_quaternion_core.sv -----
// Rotation matrix to quaternion core: takes one rigid transform per cycle and returns the
// translation unchanged with the unit quaternion of the rotation (shepperd branch choice).
// Throughput is one transfer per cycle while the output is not stalled. The pipeline has
// one stage of branch selection, ROT_FRAC_BITS+2 root stages (one result bit each),
// ROT_FRAC_BITS+3 division stages (saturation test, one quotient bit each, rounding and
// sign) and the output register. The whole pipeline holds while a result waits on the
// output, so pose.ready follows result.ready whenever the output is full.
module rotation_matrix_to_quaternion_core #(
    parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS_DEF,
    parameter int POS_WIDTH     = rmq_pkg::POS_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rmq_pose_if.sink     pose,
    rmq_result_if.source result
);
    import rmq_pkg::*;
    `include "rotation_matrix_to_quaternion_core_defines.svh"

    localparam int F   = ROT_FRAC_BITS;
    localparam int RW  = F + 2;
    localparam int NMW = F + 3;
    localparam int SW  = 2 * F + 4;
    localparam int RTW = F + 2;
    localparam int LS  = F + 2;
    localparam int LD  = F + 3;
    localparam int L   = LS + LD + 2;
    localparam int SD  = L - 2;

    typedef struct packed {
        logic [POS_WIDTH-1:0] px;
        logic [POS_WIDTH-1:0] py;
        logic [POS_WIDTH-1:0] pz;
        branch_t              br;
        logic [2:0][NMW-1:0]  num;
        logic [RW-1:0]        half;
    } side_t;

    logic                  adv;
    logic [L-1:0]          vld_reg;
    logic signed [RW-1:0]  m [9];
    logic [SW-1:0]         sq_arg;
    logic [2:0][NMW-1:0]   prep_num;
    branch_t               prep_br;
    logic [RTW-1:0]        root;
    logic [RTW:0]          half_sum;
    logic [RW-1:0]         half_c;
    logic signed [RW-1:0]  dq [3];

    logic [POS_WIDTH-1:0]  px0_reg, py0_reg, pz0_reg;
    side_t                 side_reg [SD];

    logic [POS_WIDTH-1:0]  out_px_reg, out_py_reg, out_pz_reg;
    logic signed [RW-1:0]  out_w_reg, out_x_reg, out_y_reg, out_z_reg;
    branch_t               out_br_reg;
    logic signed [RW-1:0]  w_c, x_c, y_c, z_c;
    side_t                 last;

    assign adv        = !vld_reg[L-1] || result.ready;
    assign pose.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[L-2:0], pose.valid};
    end

    assign m[0] = pose.r00;
    assign m[1] = pose.r01;
    assign m[2] = pose.r02;
    assign m[3] = pose.r10;
    assign m[4] = pose.r11;
    assign m[5] = pose.r12;
    assign m[6] = pose.r20;
    assign m[7] = pose.r21;
    assign m[8] = pose.r22;

    rmq_prep #(.ROT_FRAC_BITS(ROT_FRAC_BITS)) u_prep (
        .clk    (clk),
        .adv    (adv),
        .m      (m),
        .sq_arg (sq_arg),
        .num    (prep_num),
        .br     (prep_br)
    );

    rmq_sqrt #(.ROT_FRAC_BITS(ROT_FRAC_BITS)) u_sqrt (
        .clk  (clk),
        .adv  (adv),
        .arg  (sq_arg),
        .root (root)
    );

    // dominant component (r + 1) / 2, saturated
    assign half_sum = {1'b0, root} + (RTW+1)'(1);
    assign half_c   = half_sum[RTW] ? {1'b0, {(RW-1){1'b1}}} : RW'(half_sum[RTW:1]);

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        rmq_div #(.ROT_FRAC_BITS(ROT_FRAC_BITS)) u_div (
            .clk  (clk),
            .adv  (adv),
            .num  ($signed(side_reg[LS-1].num[c])),
            .root (root),
            .q    (dq[c])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px0_reg <= pose.pos_x_in;
            py0_reg <= pose.pos_y_in;
            pz0_reg <= pose.pos_z_in;
        end
    end

    // side data travels alongside the root and division stages
    for (genvar e = 0; e < SD; e++)
    begin : g_side
        if (e == 0)
        begin : g_head
            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[e] <= '{px: px0_reg, py: py0_reg, pz: pz0_reg,
                                     br: prep_br, num: prep_num, half: '0};
            end
        end
        else if (e == LS)
        begin : g_half
            // dominant component joins once the root is out
            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[e] <= '{px: side_reg[e-1].px, py: side_reg[e-1].py,
                                     pz: side_reg[e-1].pz, br: side_reg[e-1].br,
                                     num: side_reg[e-1].num, half: half_c};
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (adv)
                    side_reg[e] <= side_reg[e-1];
            end
        end
    end

    assign last = side_reg[SD-1];

    always_comb
    begin
        unique case (last.br)
            BR_TRACE:
            begin
                w_c = last.half; x_c = dq[0];     y_c = dq[1];     z_c = dq[2];
            end
            BR_X:
            begin
                w_c = dq[0];     x_c = last.half; y_c = dq[1];     z_c = dq[2];
            end
            BR_Y:
            begin
                w_c = dq[0];     x_c = dq[1];     y_c = last.half; z_c = dq[2];
            end
            default:
            begin
                w_c = dq[0];     x_c = dq[1];     y_c = dq[2];     z_c = last.half;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_px_reg <= last.px;
            out_py_reg <= last.py;
            out_pz_reg <= last.pz;
            out_w_reg  <= w_c;
            out_x_reg  <= x_c;
            out_y_reg  <= y_c;
            out_z_reg  <= z_c;
            out_br_reg <= last.br;
        end
    end

    assign result.valid     = vld_reg[L-1];
    assign result.pos_x_out = out_px_reg;
    assign result.pos_y_out = out_py_reg;
    assign result.pos_z_out = out_pz_reg;
    assign result.quat_w    = out_w_reg;
    assign result.quat_x    = out_x_reg;
    assign result.quat_y    = out_y_reg;
    assign result.quat_z    = out_z_reg;

    `RMQ_ASSERT_NXT(a_accept_enters, pose.valid && pose.ready, vld_reg[0],
        "accepted transfer did not enter the pipeline")
    `RMQ_ASSERT_NXT(a_stall_holds, !adv, $stable(vld_reg),
        "pipeline moved while the output was stalled")
    `RMQ_ASSERT_IMP(a_trace_w_nonneg, result.valid && out_br_reg == BR_TRACE,
        !result.quat_w[RW-1], "trace branch gave a negative scalar part")
endmodule
